// ===== sv/ccspmv_pkg.sv =====
// ccspmv_pkg: shared types and constants for the complex CSR sparse matrix-vector block
// no dependencies; imported by ccspmv_res_fifo and csr_complex_spmv
package ccspmv_pkg;

    // fixed field widths of the item and result ports
    localparam int DATA_BITS  = 32;
    localparam int ROW_BITS   = 9;
    localparam int CMD_BITS   = 2;

    // fixed point arithmetic
    localparam int FRAC_BITS  = 24;
    localparam int ACC_BITS   = 48;
    localparam int PROD_BITS  = 2 * DATA_BITS - FRAC_BITS;
    localparam int SUM_BITS   = PROD_BITS + 1;
    localparam int OUT_BITS   = ACC_BITS + 1;

    // command codes
    localparam logic [CMD_BITS-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_ENTRY = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_EMPTY = 2'd2;

    // result queue sizing (depth is a power of two)
    localparam int FIFO_DEPTH     = 8;
    localparam int FIFO_PTR_BITS  = 3;
    localparam int FIFO_CNT_BITS  = 4;

    typedef struct packed {
        logic [ROW_BITS-1:0]         row_number;
        logic signed [DATA_BITS-1:0] result_re;
        logic signed [DATA_BITS-1:0] result_im;
        logic                        saturated;
    } result_t;

endpackage

// ===== sv/ccspmv_res_fifo.sv =====
// ccspmv_res_fifo: small result queue between the accumulate pipeline and the result channel
// depends on ccspmv_pkg (result_t, queue sizing)
module ccspmv_res_fifo (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  push_valid,
    input  ccspmv_pkg::result_t                   push_item,
    output logic                                  head_valid,
    output ccspmv_pkg::result_t                   head_item,
    input  logic                                  head_ready,
    output logic [ccspmv_pkg::FIFO_CNT_BITS-1:0]  fill_count
);
    import ccspmv_pkg::*;

    result_t                  slot_reg [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_BITS-1:0] count_reg, count_next;
    logic                     pop;

    // head of queue
    assign head_valid = (count_reg != '0);
    assign head_item  = slot_reg[rd_ptr_reg];
    assign fill_count = count_reg;
    assign pop        = head_valid && head_ready;

    // pointer and count update
    always_comb begin
        wr_ptr_next = push_valid ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        case ({push_valid, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // item storage
    always_ff @(posedge aclk) begin
        if (push_valid) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    // credit check upstream must keep the queue from overflowing
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid |-> (count_reg != FIFO_CNT_BITS'(FIFO_DEPTH)))
        else $error("result queue pushed while full");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FIFO_CNT_BITS'(FIFO_DEPTH))
        else $error("result queue count out of range");

endmodule

// ===== sv/csr_complex_spmv.sv =====
// Complex sparse matrix-vector product in CSR order: one item per cycle while s_ready holds.
// A result reaches the m_ ports through these steps: vector read at the accepting edge,
// then multiply, combine, accumulate, saturate into an 8-entry queue.
// Throughput: 1 item per clock; the accumulator loop and one store port set it.
// s_ready drops only when in-flight row items plus queued results fill the queue.
// Reset clears accumulators, row counter and queue and sets rotate to 1; vector store kept.
module csr_complex_spmv #(
    parameter int VECTOR_DEPTH = 512,
    parameter int VALUE_BITS   = 32
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // configuration
    input  logic                                    cfg_we,
    input  logic                                    cfg_wdata,
    // item channel
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic [ccspmv_pkg::CMD_BITS-1:0]         s_command,
    input  logic [ccspmv_pkg::ROW_BITS-1:0]         s_index,
    input  logic signed [ccspmv_pkg::DATA_BITS-1:0] s_value_re,
    input  logic signed [ccspmv_pkg::DATA_BITS-1:0] s_value_im,
    input  logic                                    s_last_in_row,
    // result channel
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic [ccspmv_pkg::ROW_BITS-1:0]         m_row_number,
    output logic signed [ccspmv_pkg::DATA_BITS-1:0] m_result_re,
    output logic signed [ccspmv_pkg::DATA_BITS-1:0] m_result_im,
    output logic                                    m_saturated
);
    import ccspmv_pkg::*;

    localparam int INDEX_SPAN  = 1 << ROW_BITS;
    localparam int MEM_DEPTH   = (VECTOR_DEPTH > INDEX_SPAN) ? INDEX_SPAN : VECTOR_DEPTH;
    localparam int ADDR_BITS   = $clog2(MEM_DEPTH);
    localparam int WORD_BITS   = 2 * VALUE_BITS;
    localparam int CREDIT_BITS = FIFO_CNT_BITS + 1;
    localparam logic signed [OUT_BITS-1:0] SAT_HI =
        OUT_BITS'((64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1);
    localparam logic signed [OUT_BITS-1:0] SAT_LO = ~SAT_HI;

    // saturate to VALUE_BITS signed; top bit of the return is the clip flag
    function automatic logic [DATA_BITS:0] clamp(input logic signed [OUT_BITS-1:0] v);
        logic signed [OUT_BITS-1:0] c;
        logic                       clip;
        c    = v;
        clip = 1'b0;
        if (v > SAT_HI) begin
            c    = SAT_HI;
            clip = 1'b1;
        end else if (v < SAT_LO) begin
            c    = SAT_LO;
            clip = 1'b1;
        end
        return {clip, c[DATA_BITS-1:0]};
    endfunction

    logic                         accept;
    logic                         in_range;
    logic [ADDR_BITS-1:0]         mem_addr;
    logic signed [DATA_BITS-1:0]  in_re, in_im;
    logic                         is_row_item;

    logic [WORD_BITS-1:0]         vec_mem [MEM_DEPTH];
    logic [WORD_BITS-1:0]         rd_data_reg;

    // stage 1: operands
    logic                         s1_valid_reg;
    logic                         s1_emit_reg, s1_zero_reg, s1_hit_reg;
    logic signed [DATA_BITS-1:0]  s1_re_reg, s1_im_reg;
    logic signed [DATA_BITS-1:0]  x_re, x_im;
    logic signed [2*DATA_BITS-1:0] prod_rr, prod_ii, prod_ri, prod_ir;

    // stage 2: shifted products
    logic                         s2_valid_reg;
    logic                         s2_emit_reg, s2_zero_reg;
    logic signed [PROD_BITS-1:0]  s2_rr_reg, s2_ii_reg, s2_ri_reg, s2_ir_reg;
    logic signed [SUM_BITS-1:0]   sum_re, sum_im;

    // stage 3: complex product, accumulate
    logic                         s3_valid_reg;
    logic                         s3_emit_reg, s3_zero_reg;
    logic signed [SUM_BITS-1:0]   s3_re_reg, s3_im_reg;
    logic signed [ACC_BITS-1:0]   acc_re_reg, acc_im_reg;
    logic signed [ACC_BITS-1:0]   acc_add_re, acc_add_im;
    logic [ROW_BITS-1:0]          row_counter_reg;

    // stage 4: row sum, saturate
    logic                         s4_valid_reg;
    logic [ROW_BITS-1:0]          s4_row_reg;
    logic signed [ACC_BITS-1:0]   s4_re_reg, s4_im_reg;
    logic signed [OUT_BITS-1:0]   fin_re, fin_im;
    logic [DATA_BITS:0]           clamp_re, clamp_im;
    result_t                      push_item, head_item;

    logic                         rotate_reg;
    logic [FIFO_CNT_BITS-1:0]     fill_count;
    logic [CREDIT_BITS-1:0]       credit_used;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rotate_reg <= 1'b1;
        end else if (cfg_we) begin
            rotate_reg <= cfg_wdata;
        end
    end

    // input decode
    assign accept      = s_valid && s_ready;
    assign in_range    = (32'(s_index) < MEM_DEPTH);
    assign mem_addr    = s_index[ADDR_BITS-1:0];
    assign in_re       = DATA_BITS'($signed(s_value_re[VALUE_BITS-1:0]));
    assign in_im       = DATA_BITS'($signed(s_value_im[VALUE_BITS-1:0]));
    assign is_row_item = s_command inside {CMD_ENTRY, CMD_EMPTY};

    // credit: results in flight plus queued never exceed the queue depth
    assign credit_used = CREDIT_BITS'(fill_count) + CREDIT_BITS'(s1_valid_reg)
                       + CREDIT_BITS'(s2_valid_reg) + CREDIT_BITS'(s3_valid_reg)
                       + CREDIT_BITS'(s4_valid_reg);
    assign s_ready     = (credit_used < CREDIT_BITS'(FIFO_DEPTH));

    // vector store; one item per edge, so a load and a later read never share an edge
    // and a read issued after a load already sees it
    always_ff @(posedge aclk) begin
        if (accept && (s_command == CMD_LOAD) && in_range) begin
            vec_mem[mem_addr] <= {in_im[VALUE_BITS-1:0], in_re[VALUE_BITS-1:0]};
        end
        if (accept) begin
            rd_data_reg <= vec_mem[mem_addr];
        end
    end

    // pipeline valids and accumulator state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            s3_valid_reg    <= 1'b0;
            s4_valid_reg    <= 1'b0;
            acc_re_reg      <= '0;
            acc_im_reg      <= '0;
            row_counter_reg <= '0;
        end else begin
            s1_valid_reg <= accept && is_row_item;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg && s3_emit_reg;
            if (s3_valid_reg) begin
                if (s3_emit_reg) begin
                    acc_re_reg      <= '0;
                    acc_im_reg      <= '0;
                    row_counter_reg <= row_counter_reg + 1'b1;
                end else begin
                    acc_re_reg <= acc_add_re;
                    acc_im_reg <= acc_add_im;
                end
            end
        end
    end

    // stage 1 payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_emit_reg <= (s_command == CMD_EMPTY) || s_last_in_row;
            s1_zero_reg <= (s_command == CMD_EMPTY);
            s1_hit_reg  <= in_range;
            s1_re_reg   <= in_re;
            s1_im_reg   <= in_im;
        end
    end

    // multiply by the stored element; out-of-range column reads as zero
    assign x_re    = s1_hit_reg ? DATA_BITS'($signed(rd_data_reg[VALUE_BITS-1:0])) : '0;
    assign x_im    = s1_hit_reg ? DATA_BITS'($signed(rd_data_reg[WORD_BITS-1:VALUE_BITS])) : '0;
    assign prod_rr = s1_re_reg * x_re;
    assign prod_ii = s1_im_reg * x_im;
    assign prod_ri = s1_re_reg * x_im;
    assign prod_ir = s1_im_reg * x_re;

    // stage 2 payload: each product floored to Q16.24
    always_ff @(posedge aclk) begin
        s2_emit_reg <= s1_emit_reg;
        s2_zero_reg <= s1_zero_reg;
        s2_rr_reg   <= prod_rr[2*DATA_BITS-1:FRAC_BITS];
        s2_ii_reg   <= prod_ii[2*DATA_BITS-1:FRAC_BITS];
        s2_ri_reg   <= prod_ri[2*DATA_BITS-1:FRAC_BITS];
        s2_ir_reg   <= prod_ir[2*DATA_BITS-1:FRAC_BITS];
    end

    // complex product terms
    assign sum_re = SUM_BITS'(s2_rr_reg) - SUM_BITS'(s2_ii_reg);
    assign sum_im = SUM_BITS'(s2_ri_reg) + SUM_BITS'(s2_ir_reg);

    always_ff @(posedge aclk) begin
        s3_emit_reg <= s2_emit_reg;
        s3_zero_reg <= s2_zero_reg;
        s3_re_reg   <= sum_re;
        s3_im_reg   <= sum_im;
    end

    // accumulate, wrapping at the accumulator width
    assign acc_add_re = acc_re_reg + ACC_BITS'(s3_re_reg);
    assign acc_add_im = acc_im_reg + ACC_BITS'(s3_im_reg);

    always_ff @(posedge aclk) begin
        s4_row_reg <= row_counter_reg;
        s4_re_reg  <= s3_zero_reg ? '0 : acc_add_re;
        s4_im_reg  <= s3_zero_reg ? '0 : acc_add_im;
    end

    // optional -i rotation at full precision, then saturate
    always_comb begin
        if (rotate_reg) begin
            fin_re = OUT_BITS'(s4_im_reg);
            fin_im = -OUT_BITS'(s4_re_reg);
        end else begin
            fin_re = OUT_BITS'(s4_re_reg);
            fin_im = OUT_BITS'(s4_im_reg);
        end
        clamp_re             = clamp(fin_re);
        clamp_im             = clamp(fin_im);
        push_item.row_number = s4_row_reg;
        push_item.result_re  = clamp_re[DATA_BITS-1:0];
        push_item.result_im  = clamp_im[DATA_BITS-1:0];
        push_item.saturated  = clamp_re[DATA_BITS] || clamp_im[DATA_BITS];
    end

    ccspmv_res_fifo u_res_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (s4_valid_reg),
        .push_item  (push_item),
        .head_valid (m_valid),
        .head_item  (head_item),
        .head_ready (m_ready),
        .fill_count (fill_count)
    );

    assign m_row_number = head_item.row_number;
    assign m_result_re  = head_item.result_re;
    assign m_result_im  = head_item.result_im;
    assign m_saturated  = head_item.saturated;

    // a load never occupies a pipeline slot
    a_load_no_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_command == CMD_LOAD)) |=> !s1_valid_reg)
        else $error("vector load entered the multiply pipeline");

    // closing a row leaves the accumulator clear
    a_acc_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (s3_valid_reg && s3_emit_reg) |=> (acc_re_reg == '0) && (acc_im_reg == '0))
        else $error("accumulator not cleared after row close");

    // row counter steps by one per row close
    a_row_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (s3_valid_reg && s3_emit_reg) |=> (row_counter_reg == $past(row_counter_reg) + 1'b1))
        else $error("row counter did not advance on row close");

endmodule
